// File: hw/rtl/pn3d_pkg.sv
// shared constants, tables and arithmetic helpers for the 3d noise pipeline
`default_nettype none
package pn3d_pkg;
  localparam int FracBits = 16;
  localparam int PermSize = 256;
  localparam int CellBits = 8;
  localparam int OutBits = FracBits + 3;
  localparam int OneFx = 1 << FracBits;
  localparam int HalfFx = 1 << (FracBits - 1);
  localparam int DotBits = FracBits + 3;

  typedef logic [CellBits-1:0] cell_t;
  typedef logic [FracBits-1:0] frac_t;
  typedef logic signed [FracBits+1:0] ofs_t;
  typedef logic signed [DotBits-1:0] dot_t;
  typedef logic [FracBits:0] wgt_t;

  localparam logic [7:0] PERM [PermSize] = '{
    8'd151,8'd160,8'd137,8'd91,8'd90,8'd15,8'd131,8'd13,8'd201,8'd95,8'd96,8'd53,8'd194,
    8'd233,8'd7,8'd225,8'd140,8'd36,8'd103,8'd30,8'd69,8'd142,8'd8,8'd99,8'd37,8'd240,
    8'd21,8'd10,8'd23,8'd190,8'd6,8'd148,8'd247,8'd120,8'd234,8'd75,8'd0,8'd26,8'd197,
    8'd62,8'd94,8'd252,8'd219,8'd203,8'd117,8'd35,8'd11,8'd32,8'd57,8'd177,8'd33,8'd88,
    8'd237,8'd149,8'd56,8'd87,8'd174,8'd20,8'd125,8'd136,8'd171,8'd168,8'd68,8'd175,
    8'd74,8'd165,8'd71,8'd134,8'd139,8'd48,8'd27,8'd166,8'd77,8'd146,8'd158,8'd231,
    8'd83,8'd111,8'd229,8'd122,8'd60,8'd211,8'd133,8'd230,8'd220,8'd105,8'd92,8'd41,
    8'd55,8'd46,8'd245,8'd40,8'd244,8'd102,8'd143,8'd54,8'd65,8'd25,8'd63,8'd161,8'd1,
    8'd216,8'd80,8'd73,8'd209,8'd76,8'd132,8'd187,8'd208,8'd89,8'd18,8'd169,8'd200,
    8'd196,8'd135,8'd130,8'd116,8'd188,8'd159,8'd86,8'd164,8'd100,8'd109,8'd198,8'd173,
    8'd186,8'd3,8'd64,8'd52,8'd217,8'd226,8'd250,8'd124,8'd123,8'd5,8'd202,8'd38,
    8'd147,8'd118,8'd126,8'd255,8'd82,8'd85,8'd212,8'd207,8'd206,8'd59,8'd227,8'd47,
    8'd16,8'd58,8'd17,8'd182,8'd189,8'd28,8'd42,8'd223,8'd183,8'd170,8'd213,8'd119,
    8'd248,8'd152,8'd2,8'd44,8'd154,8'd163,8'd70,8'd221,8'd153,8'd101,8'd155,8'd167,
    8'd43,8'd172,8'd9,8'd129,8'd22,8'd39,8'd253,8'd19,8'd98,8'd108,8'd110,8'd79,
    8'd113,8'd224,8'd232,8'd178,8'd185,8'd112,8'd104,8'd218,8'd246,8'd97,8'd228,
    8'd251,8'd34,8'd242,8'd193,8'd238,8'd210,8'd144,8'd12,8'd191,8'd179,8'd162,8'd241,
    8'd81,8'd51,8'd145,8'd235,8'd249,8'd14,8'd239,8'd107,8'd49,8'd192,8'd214,8'd31,
    8'd181,8'd199,8'd106,8'd157,8'd184,8'd84,8'd204,8'd176,8'd115,8'd121,8'd50,8'd45,
    8'd127,8'd4,8'd150,8'd254,8'd138,8'd236,8'd205,8'd93,8'd222,8'd114,8'd67,8'd29,
    8'd24,8'd72,8'd243,8'd141,8'd128,8'd195,8'd78,8'd66,8'd215,8'd61,8'd156,8'd180
  };

  // rounded product scaling: floor((p + half) / one)
  function automatic logic signed [63:0] rnd_fx(input logic signed [63:0] p);
    logic signed [63:0] q;
    q = p + 64'(HalfFx);
    return q >>> FracBits;
  endfunction

  function automatic dot_t grad_dot(input logic [3:0] h, input ofs_t x, input ofs_t y,
                                    input ofs_t z);
    ofs_t u;
    ofs_t v;
    dot_t su;
    dot_t sv;
    u = (h < 4'd8 || h == 4'd12 || h == 4'd13) ? x : y;
    v = (h < 4'd4 || h == 4'd12 || h == 4'd13) ? y : z;
    su = h[0] ? -DotBits'(u) : DotBits'(u);
    sv = h[1] ? -DotBits'(v) : DotBits'(v);
    return su + sv;
  endfunction
endpackage
`default_nettype wire

// File: hw/rtl/perlin_noise_3d_unit.sv
// top level of the 3d gradient noise pipeline
// stages: split and three lookups, gradient dots, x, y and z lerps, output register
// throughput: one point per cycle; the whole pipe advances when the output stage is free
// each lerp holds one multiply; hashing uses three chained rom stages
// reset: rst_n synchronous active low clears all valid bits, payload is not reset
`default_nettype none
module perlin_noise_3d_unit import pn3d_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [95:0] in_tdata,  // coord_x, coord_y, coord_z
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [23:0]      out_tdata  // noise_value, zero fill
);
  localparam int Stages = 8;
  logic [Stages-1:0] v_r;
  logic en;
  assign en = !v_r[Stages-1] || out_tready;
  assign in_tready = en;

  always_ff @(posedge clk) begin
    if (!rst_n) v_r <= '0;
    else if (en) v_r <= {v_r[Stages-2:0], in_tvalid};
  end

  // stage 1: split, first lookup
  cell_t cy1_r, cz1_r;
  frac_t f1_r [3];
  logic [7:0] a1_r [2];
  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < 3; k++) f1_r[k] <= in_tdata[32*k +: FracBits];
      cy1_r <= in_tdata[32+FracBits +: CellBits];
      cz1_r <= in_tdata[64+FracBits +: CellBits];
      a1_r[0] <= PERM[in_tdata[FracBits +: CellBits]];
      a1_r[1] <= PERM[cell_t'(in_tdata[FracBits +: CellBits] + 8'd1)];
    end
  end

  // stage 2: second lookup, four xy pairs
  cell_t cz2_r;
  frac_t f2_r [3];
  logic [7:0] b2_r [4];
  always_ff @(posedge clk) begin
    if (en) begin
      f2_r <= f1_r;
      cz2_r <= cz1_r;
      for (int k = 0; k < 4; k++)
        b2_r[k] <= PERM[cell_t'(a1_r[k%2] + cy1_r + cell_t'(k/2))];
    end
  end

  // stage 3: third lookup, hash of eight corners
  frac_t f3_r [3];
  logic [3:0] h3_r [8];
  always_ff @(posedge clk) begin
    if (en) begin
      f3_r <= f2_r;
      for (int k = 0; k < 8; k++)
        h3_r[k] <= PERM[cell_t'(b2_r[k%4] + cz2_r + cell_t'(k/4))][3:0];
    end
  end

  // stage 4: gradient dots
  dot_t g4_r [8];
  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < 8; k++)
        g4_r[k] <= grad_dot(h3_r[k],
          k[0] ? ofs_t'(f3_r[0]) - ofs_t'(OneFx) : ofs_t'(f3_r[0]),
          k[1] ? ofs_t'(f3_r[1]) - ofs_t'(OneFx) : ofs_t'(f3_r[1]),
          k[2] ? ofs_t'(f3_r[2]) - ofs_t'(OneFx) : ofs_t'(f3_r[2]));
    end
  end

  // fade weights, valid at stage 4
  wgt_t w_x, w_y, w_z;
  pn3d_fade u_fx (.clk(clk), .en(en), .t_in(f1_r[0]), .w_out(w_x));
  pn3d_fade u_fy (.clk(clk), .en(en), .t_in(f1_r[1]), .w_out(w_y));
  pn3d_fade u_fz (.clk(clk), .en(en), .t_in(f1_r[2]), .w_out(w_z));

  function automatic dot_t lerp(input wgt_t w, input dot_t p, input dot_t q);
    logic signed [63:0] m;
    m = $signed(64'(w)) * (64'(q) - 64'(p));
    return dot_t'(64'(p) + rnd_fx(m));
  endfunction

  // stage 5: x lerps
  dot_t x5_r [4];
  wgt_t wy5_r, wz5_r, wz6_r;
  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < 4; k++) x5_r[k] <= lerp(w_x, g4_r[2*k], g4_r[2*k+1]);
      wy5_r <= w_y;
      wz5_r <= w_z;
    end
  end

  // stage 6: y lerps
  dot_t y6_r [2];
  always_ff @(posedge clk) begin
    if (en) begin
      y6_r[0] <= lerp(wy5_r, x5_r[0], x5_r[1]);
      y6_r[1] <= lerp(wy5_r, x5_r[2], x5_r[3]);
      wz6_r <= wz5_r;
    end
  end

  // stage 7: z lerp, stage 8: output register
  dot_t r7_r, r8_r;
  always_ff @(posedge clk) begin
    if (en) begin
      r7_r <= lerp(wz6_r, y6_r[0], y6_r[1]);
      r8_r <= r7_r;
    end
  end

  assign out_tvalid = v_r[Stages-1];
  assign out_tdata = {5'b0, r8_r[OutBits-1:0]};
endmodule
`default_nettype wire

// File: hw/rtl/pn3d_fade.sv
// pipelined quintic fade weight, three register stages
`default_nettype none
module pn3d_fade import pn3d_pkg::*; (
  input  wire logic  clk,
  input  wire logic  en,
  input  wire frac_t t_in,
  output wgt_t       w_out
);
  frac_t t1_r;
  logic signed [FracBits+5:0] b_r, b2_r;
  logic [FracBits:0] c_r, d_r;
  wgt_t w_r;
  logic signed [63:0] a_v, b_v, c_v, d_v, w_v;

  always_comb begin
    a_v = 64'(6) * 64'(t_in) - 64'(15 * OneFx);
    b_v = rnd_fx(64'(t_in) * a_v) + 64'(10 * OneFx);
    c_v = rnd_fx(64'(t_in) * 64'(t_in));
    d_v = rnd_fx($signed(64'(c_r)) * 64'(t1_r));
    w_v = rnd_fx($signed(64'(d_r)) * 64'(b2_r));
  end

  always_ff @(posedge clk) begin
    if (en) begin
      t1_r <= t_in;
      b_r  <= (FracBits+6)'(b_v);
      c_r  <= (FracBits+1)'(c_v);
      d_r  <= (FracBits+1)'(d_v);
      b2_r <= b_r;
      if (w_v < 0) w_r <= '0;
      else if (w_v > 64'(OneFx)) w_r <= wgt_t'(OneFx);
      else w_r <= wgt_t'(w_v);
    end
  end

  assign w_out = w_r;
endmodule
`default_nettype wire

// File: hw/rtl/pn3d_checker.sv
// port checker for the noise unit and its bind
`default_nettype none
module pn3d_checker (
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic        in_tready,
  input wire logic        out_tvalid,
  input wire logic        out_tready,
  input wire logic [23:0] out_tdata
);
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata)) else $error("out hold");
  a_rdy: assert property (@(posedge clk) disable iff (!rst_n)
    !out_tvalid |-> in_tready) else $error("ready while empty");
  a_stall: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |-> !in_tready) else $error("accept during stall");
  a_fill: assert property (@(posedge clk) disable iff (!rst_n)
    out_tdata[23:19] == 5'b0) else $error("fill bits");
endmodule

bind perlin_noise_3d_unit pn3d_checker u_chk (.*);
`default_nettype wire

// File: tb/perlin_noise_3d_unit_checker.sv
// checker for the 3d noise unit: predicts each result from the accepted points and compares
module perlin_noise_3d_unit_checker import pn3d_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  input  wire logic        in_tready,
  input  wire logic [95:0] in_tdata,  // coord_x, coord_y, coord_z
  input  wire logic        out_tvalid,
  input  wire logic        out_tready,
  input  wire logic [23:0] out_tdata, // noise_value, zero fill
  output int               errors,
  output int               pending,
  output int               results_seen
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam longint One = longint'(1) << FracBits;

  logic [OutBits-1:0] expected_noise[$];

  function automatic longint scale_round(longint p);
    longint q;
    q = p + (One >>> 1);
    return q >>> FracBits;
  endfunction

  function automatic logic [3:0] lattice_hash(int cx, int cy, int cz);
    int a;
    int b;
    a = PERM[cx & 255];
    b = PERM[(a + cy) & 255];
    return PERM[(b + cz) & 255][3:0];
  endfunction

  function automatic longint gradient(logic [3:0] h, longint x, longint y, longint z);
    longint u;
    longint v;
    u = (h < 8 || h == 12 || h == 13) ? x : y;
    v = (h < 4 || h == 12 || h == 13) ? y : z;
    return (h[0] ? -u : u) + (h[1] ? -v : v);
  endfunction

  function automatic longint quintic(longint t);
    longint a;
    longint b;
    longint c;
    longint d;
    longint w;
    a = 6 * t - 15 * One;
    b = scale_round(t * a) + 10 * One;
    c = scale_round(t * t);
    d = scale_round(c * t);
    w = scale_round(d * b);
    if (w < 0) w = 0;
    if (w > One) w = One;
    return w;
  endfunction

  function automatic longint blend(longint w, longint p, longint q);
    return p + scale_round(w * (q - p));
  endfunction

  function automatic logic [OutBits-1:0] noise_at(logic [95:0] pt);
    int c[3];
    longint f[3];
    longint g[3];
    longint n[8];
    longint wx;
    longint wy;
    longint wz;
    longint y0;
    longint y1;
    longint r;
    for (int i = 0; i < 3; i++) begin
      c[i] = pt[32*i+FracBits +: 8];
      f[i] = longint'(pt[32*i +: FracBits]);
      g[i] = f[i] - One;
    end
    for (int k = 0; k < 8; k++) begin
      n[k] = gradient(lattice_hash(c[0] + k[0], c[1] + k[1], c[2] + k[2]),
                      k[0] ? g[0] : f[0], k[1] ? g[1] : f[1], k[2] ? g[2] : f[2]);
    end
    wx = quintic(f[0]);
    wy = quintic(f[1]);
    wz = quintic(f[2]);
    y0 = blend(wy, blend(wx, n[0], n[1]), blend(wx, n[2], n[3]));
    y1 = blend(wy, blend(wx, n[4], n[5]), blend(wx, n[6], n[7]));
    r = blend(wz, y0, y1);
    return r[OutBits-1:0];
  endfunction

  task automatic report_mismatch(string what);
    $display("mismatch at %0t: %s", $time, what);
    errors++;
  endtask

  initial begin
    errors = 0;
    results_seen = 0;
  end

  assign pending = expected_noise.size();

  always @(posedge clk) begin
    logic [OutBits-1:0] want;
    if (rst_n) begin
      if (in_tvalid && in_tready) expected_noise.push_back(noise_at(in_tdata));
      if (out_tvalid && out_tready) begin
        results_seen++;
        if (expected_noise.size() == 0) begin
          report_mismatch($sformatf("unexpected result %h", out_tdata));
        end else begin
          want = expected_noise.pop_front();
          if (out_tdata[OutBits-1:0] !== want)
            report_mismatch($sformatf("noise_value %h, expected %h",
                                      out_tdata[OutBits-1:0], want));
          if (out_tdata[23:OutBits] !== '0)
            report_mismatch($sformatf("fill bits %h not zero", out_tdata[23:OutBits]));
        end
      end
    end
  end
endmodule

// File: tb/perlin_noise_3d_unit_test.sv
// top of the 3d noise unit testbench: stimulus, stalls, watchdog and verdict
module perlin_noise_3d_unit_test;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int RandomPoints = 1400;
  localparam int IdleLimit = 20000;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [95:0] in_tdata = '0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [23:0] out_tdata;
  int          errors;
  int          pending;
  int          results_seen;
  int          idle_cycles = 0;
  int          points_sent = 0;

  always #1 clk = ~clk;

  perlin_noise_3d_unit uut (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata)
  );

  perlin_noise_3d_unit_checker checker_i (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .errors(errors), .pending(pending), .results_seen(results_seen)
  );

  function automatic int gap_length();
    int r;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(4, 40);
  endfunction

  function automatic logic [31:0] random_coord();
    case ($urandom_range(0, 5))
      0: return $urandom();
      1: return {16'(int'($urandom_range(0, 8)) - 4), 16'($urandom())};
      2: return {16'($urandom()), 16'h0000} | 32'($urandom_range(0, 1));
      3: return {16'($urandom()), 16'hffff - 16'($urandom_range(0, 3))};
      4: return {16'($urandom()), 16'h8000};
      default: return {16'($urandom()), 16'($urandom())};
    endcase
  endfunction

  // holds one transfer on the input channel, then idles a random while, which may be none
  task automatic send_point(logic [31:0] x, logic [31:0] y, logic [31:0] z);
    int gap;
    in_tvalid <= 1'b1;
    in_tdata <= {z, y, x};
    do @(posedge clk); while (!in_tready);
    points_sent++;
    gap = gap_length();
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // output stall pattern with bursts of no back-pressure
  initial begin
    int stall;
    @(posedge clk);
    while (1) begin
      out_tready <= 1'b1;
      repeat ($urandom_range(1, 30)) @(posedge clk);
      stall = gap_length();
      if (stall > 0) begin
        out_tready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready) ||
        (!in_tvalid && pending == 0))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IdleLimit) begin
      $display("watchdog: no transfer for %0d cycles", IdleLimit);
      $display("perlin_noise_3d_unit test failed");
      $finish;
    end
  end

  initial begin
    logic [31:0] edge_vals[12];
    int wait_cycles;
    edge_vals = '{32'h0000_0000, 32'hffff_ffff, 32'h7fff_ffff, 32'h8000_0000,
                  32'h0001_0000, 32'hffff_0000, 32'h0000_ffff, 32'h0000_8000,
                  32'h00ff_ffff, 32'h0100_0000, 32'hfffe_0001, 32'h5555_aaaa};
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    // field extremes, negative floors, fade near one and cell wrap
    for (int i = 0; i < 12; i++) send_point(edge_vals[i], edge_vals[(i + 5) % 12],
                                             edge_vals[(i + 9) % 12]);
    send_point(32'hffff_fffe, 32'hffff_ffff, 32'h00ff_ffff);
    send_point(32'h0000_fffe, 32'h0000_ffff, 32'h0000_fffd);
    send_point(32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
    send_point(32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff);
    send_point(32'hff80_4000, 32'h0080_c000, 32'hfff0_0001);
    // hold off until the pipe has drained
    in_tvalid <= 1'b0;
    while (pending != 0) @(posedge clk);
    for (int i = 0; i < RandomPoints; i++)
      send_point(random_coord(), random_coord(), random_coord());
    in_tvalid <= 1'b0;
    wait_cycles = 0;
    while (pending != 0 && wait_cycles < 100000) begin
      @(posedge clk);
      wait_cycles++;
    end
    repeat (20) @(posedge clk);
    $display("covered %0d points with %0d results: extremes, negative coordinates,",
             points_sent, results_seen);
    $display("fraction edges and random stalls on both channels");
    if (errors == 0 && pending == 0) begin
      $display("perlin_noise_3d_unit test passed");
    end else begin
      $display("perlin_noise_3d_unit test failed");
    end
    $finish;
  end
endmodule
